FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the checker modules.
// Each macro expects a signal named clk in the enclosing scope; the first two also expect rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define HFP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hfp assertion failed");

// Next-cycle implication, off while reset is high.
`define HFP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hfp assertion failed");

// Next-cycle implication that also watches reset itself.
`define HFP_ASSERT_ALWAYS_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("hfp assertion failed");

`endif

FILE: hw/rtl/hfp_pkg.sv
// Package for the header/tail frame parser: frame layout, phase and
// register index types. No dependencies.
`timescale 1ns / 1ps

package hfp_pkg;

  localparam int FRAME_BYTES = 13;
  localparam int BYTE_W      = 8;
  localparam int WORD_W      = 32;
  localparam int POS_W       = $clog2(FRAME_BYTES + 1);
  localparam int CFG_IDX_W   = 2;

  // Frame offsets
  localparam int MODE_AT   = 2;
  localparam int WORD_A_AT = 3;
  localparam int WORD_B_AT = 7;
  localparam int TAIL_A_AT = 11;
  localparam int TAIL_B_AT = 12;

  localparam int OUT_TDATA_W = BYTE_W + 2 * WORD_W;

  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_SECOND = 2'd1,
    PH_BODY   = 2'd2
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEADER_FIRST  = 2'd0,
    REG_HEADER_SECOND = 2'd1,
    REG_TAIL_FIRST    = 2'd2,
    REG_TAIL_SECOND   = 2'd3
  } cfg_reg_t;

endpackage

FILE: hw/rtl/header_tail_frame_parser_top.sv
// m_tvalid rises in the cycle after the last frame byte is accepted.
// Throughput: one byte per cycle while s_tready is high; each byte passes
// through the phase/position registers and one compare stage into the result register.
// s_tready drops only on the last frame byte while an earlier result still waits.
// Reset (rst, synchronous): clears phase, position, output valid and config registers.
`timescale 1ns / 1ps

module header_tail_frame_parser_top import hfp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  // configuration write port
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [BYTE_W-1:0]      cfg_data,
  // byte stream in
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [BYTE_W-1:0]      s_tdata,   // [7:0] rx_byte
  // frame results out
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata    // [7:0] frame_mode, [39:8] first_word,
                                            // [71:40] second_word
);

  logic [BYTE_W-1:0] header_first;
  logic [BYTE_W-1:0] header_second;
  logic [BYTE_W-1:0] tail_first;
  logic [BYTE_W-1:0] tail_second;

  phase_t            phase;
  phase_t            phase_next;
  logic [POS_W-1:0]  byte_position;
  logic [POS_W-1:0]  byte_position_next;

  // Only offsets that are read back are kept; the headers are checked on arrival.
  logic [BYTE_W-1:0] frame_store [MODE_AT:TAIL_A_AT];

  logic              accept;
  logic              store_en;
  logic              frame_end;
  logic              emit;

  assign accept = s_tvalid && s_tready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      header_first  <= '0;
      header_second <= '0;
      tail_first    <= '0;
      tail_second   <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_HEADER_FIRST:  header_first  <= cfg_data;
        REG_HEADER_SECOND: header_second <= cfg_data;
        REG_TAIL_FIRST:    tail_first    <= cfg_data;
        REG_TAIL_SECOND:   tail_second   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next phase and position
  always_comb begin
    phase_next         = phase;
    byte_position_next = byte_position;
    if (accept) begin
      case (phase)
        PH_HUNT: begin
          if (s_tdata == header_first) begin
            phase_next         = PH_SECOND;
            byte_position_next = POS_W'(1);
          end
        end
        PH_SECOND: begin
          if (s_tdata == header_second) begin
            phase_next         = PH_BODY;
            byte_position_next = POS_W'(MODE_AT);
          end else begin
            phase_next = PH_HUNT;
          end
        end
        default: begin
          byte_position_next = byte_position + POS_W'(1);
          if (byte_position >= POS_W'(TAIL_B_AT)) begin
            phase_next = PH_HUNT;
          end
        end
      endcase
    end
  end

  // Stream control and frame completion
  always_comb begin
    frame_end = (phase != PH_HUNT) && (phase != PH_SECOND)
                && (byte_position >= POS_W'(TAIL_B_AT));
    store_en  = accept && (phase != PH_HUNT) && (phase != PH_SECOND);
    // hold the last byte back while the previous result has not been taken
    s_tready  = !(frame_end && m_tvalid && !m_tready);
    emit      = accept && frame_end
                && (frame_store[TAIL_A_AT] == tail_first)
                && (s_tdata == tail_second);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      byte_position <= '0;
    end else begin
      phase         <= phase_next;
      byte_position <= byte_position_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = MODE_AT; i <= TAIL_A_AT; i++) begin
      if (store_en && (byte_position == POS_W'(i))) begin
        frame_store[i] <= s_tdata;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= {frame_store[WORD_B_AT + 3], frame_store[WORD_B_AT + 2],
                  frame_store[WORD_B_AT + 1], frame_store[WORD_B_AT],
                  frame_store[WORD_A_AT + 3], frame_store[WORD_A_AT + 2],
                  frame_store[WORD_A_AT + 1], frame_store[WORD_A_AT],
                  frame_store[MODE_AT]};
    end
  end

endmodule

FILE: hw/rtl/hfp_checker.sv
// Port-level checker for the frame parser, bound to the top level.
// Depends on hfp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hfp_checker import hfp_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  `HFP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
  `HFP_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata))
  `HFP_ASSERT_NOW(a_result_from_request, $rose(m_tvalid), $past(s_tvalid && s_tready))
  `HFP_ASSERT_NOW(a_stall_only_on_pending, !s_tready, m_tvalid)
  `HFP_ASSERT_ALWAYS_NEXT(a_reset_clears_out, rst, !m_tvalid)

endmodule

bind header_tail_frame_parser_top hfp_checker u_hfp_checker (.*);

FILE: dv/hfp_frame_checker.sv
// Frame checker for header_tail_frame_parser_top: tracks register writes and
// accepted bytes, predicts the decoded frames and compares them with the results.
// Depends on hfp_pkg.
`timescale 1ns / 1ps

module hfp_frame_checker import hfp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [BYTE_W-1:0]      cfg_data,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [BYTE_W-1:0]      s_tdata,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_TDATA_W-1:0] m_tdata,
  output int                     fail_count,
  output int                     due_count,
  output int                     frames_checked
);

  typedef struct packed {
    logic [BYTE_W-1:0] mode;
    logic [WORD_W-1:0] first_word;
    logic [WORD_W-1:0] second_word;
  } frame_fields_t;

  logic [BYTE_W-1:0] hdr_first, hdr_second, tail_first, tail_second;
  phase_t            hunt;
  logic [3:0]        pos;
  logic [BYTE_W-1:0] frame_buf [FRAME_BYTES];
  frame_fields_t     due_frames [$];

  initial begin
    fail_count     = 0;
    due_count      = 0;
    frames_checked = 0;
  end

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] want,
                                 input logic [WORD_W-1:0] got);
    $display("%0t frame check: %s expected %0h got %0h", $time, what, want, got);
    fail_count++;
  endtask

  task automatic absorb_byte(input logic [BYTE_W-1:0] b);
    frame_fields_t f;
    case (hunt)
      PH_HUNT: begin
        if (b == hdr_first) begin
          frame_buf[0] = b;
          pos          = 4'd1;
          hunt         = PH_SECOND;
        end
      end
      PH_SECOND: begin
        // a bad second header is dropped, not retried as a first header
        if (b == hdr_second) begin
          frame_buf[1] = b;
          pos          = 4'd2;
          hunt         = PH_BODY;
        end else begin
          hunt = PH_HUNT;
        end
      end
      default: begin
        if (pos < FRAME_BYTES) begin
          frame_buf[pos] = b;
          pos            = pos + 4'd1;
        end
        if (pos >= FRAME_BYTES || pos == 4'd0) begin
          hunt = PH_HUNT;
          if (frame_buf[TAIL_A_AT] == tail_first && frame_buf[TAIL_B_AT] == tail_second) begin
            f.mode        = frame_buf[MODE_AT];
            f.first_word  = {frame_buf[WORD_A_AT + 3], frame_buf[WORD_A_AT + 2],
                             frame_buf[WORD_A_AT + 1], frame_buf[WORD_A_AT]};
            f.second_word = {frame_buf[WORD_B_AT + 3], frame_buf[WORD_B_AT + 2],
                             frame_buf[WORD_B_AT + 1], frame_buf[WORD_B_AT]};
            due_frames.push_back(f);
          end
        end
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    frame_fields_t seen, want;
    if (rst) begin
      hdr_first   = '0;
      hdr_second  = '0;
      tail_first  = '0;
      tail_second = '0;
      hunt        = PH_HUNT;
      pos         = '0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_HEADER_FIRST:  hdr_first   = cfg_data;
          REG_HEADER_SECOND: hdr_second  = cfg_data;
          REG_TAIL_FIRST:    tail_first  = cfg_data;
          REG_TAIL_SECOND:   tail_second = cfg_data;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        seen.mode        = m_tdata[BYTE_W-1:0];
        seen.first_word  = m_tdata[BYTE_W +: WORD_W];
        seen.second_word = m_tdata[BYTE_W + WORD_W +: WORD_W];
        if (due_frames.size() == 0) begin
          report_mismatch("frame with nothing due, mode", '0, WORD_W'(seen.mode));
        end else begin
          want = due_frames.pop_front();
          if (seen.mode != want.mode)
            report_mismatch("frame_mode", WORD_W'(want.mode), WORD_W'(seen.mode));
          if (seen.first_word != want.first_word)
            report_mismatch("first_word", want.first_word, seen.first_word);
          if (seen.second_word != want.second_word)
            report_mismatch("second_word", want.second_word, seen.second_word);
          frames_checked++;
        end
      end
      if (s_tvalid && s_tready)
        absorb_byte(s_tdata);
    end
    due_count <= due_frames.size();
  end

endmodule

FILE: dv/tb.sv
// Testbench top for header_tail_frame_parser_top: clock, reset, byte stream
// and register stimulus, result-side stalls and the verdict.
// Depends on hfp_pkg, header_tail_frame_parser_top and hfp_frame_checker.
`timescale 1ns / 1ps

module tb;
  import hfp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [BYTE_W-1:0]      cfg_data  = '0;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [BYTE_W-1:0]      s_tdata   = '0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  int fail_count, due_count, frames_checked;
  int idle_pct      = 0;
  int stall_pct     = 0;
  int bytes_sent    = 0;
  int settings_used = 0;
  int unsigned cycles = 0;

  // register values currently loaded, used to build frames
  logic [BYTE_W-1:0] hf = '0, hs = '0, tf = '0, ts = '0;

  header_tail_frame_parser_top uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  hfp_frame_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .fail_count     (fail_count),
    .due_count      (due_count),
    .frames_checked (frames_checked)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic load_regs(input logic [BYTE_W-1:0] v0, input logic [BYTE_W-1:0] v1,
                           input logic [BYTE_W-1:0] v2, input logic [BYTE_W-1:0] v3);
    cfg_reg_t          idx  [4] = '{REG_HEADER_FIRST, REG_HEADER_SECOND,
                                    REG_TAIL_FIRST, REG_TAIL_SECOND};
    logic [BYTE_W-1:0] vals [4];
    vals = '{v0, v1, v2, v3};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    hf = v0;
    hs = v1;
    tf = v2;
    ts = v3;
    settings_used++;
  endtask

  // Hold tvalid across back-to-back requests; drop it only for an idle gap.
  task automatic send_rx(input logic [BYTE_W-1:0] b);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_frame(input bit tails_ok);
    logic [BYTE_W-1:0] t0, t1;
    int spoil;
    t0 = tf;
    t1 = ts;
    if (!tails_ok) begin
      spoil = $urandom_range(0, 2);
      if (spoil != 1) t0 = tf ^ 8'($urandom_range(1, 255));
      if (spoil != 0) t1 = ts ^ 8'($urandom_range(1, 255));
    end
    send_rx(hf);
    send_rx(hs);
    repeat (FRAME_BYTES - 4) send_rx(8'($urandom_range(0, 255)));
    send_rx(t0);
    send_rx(t1);
  endtask

  task automatic run_phase(input int idle, input int stall,
                           input logic [BYTE_W-1:0] v0, input logic [BYTE_W-1:0] v1,
                           input logic [BYTE_W-1:0] v2, input logic [BYTE_W-1:0] v3);
    int start, good, pick;
    bit paused;
    load_regs(v0, v1, v2, v3);
    idle_pct  = idle;
    stall_pct = stall;
    start     = bytes_sent;
    good      = 0;
    paused    = 1'b0;
    while (bytes_sent - start < 100 || good < 5) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_frame(1'b1);
        good++;
      end else if (pick < 82) begin
        send_frame(1'b0);
      end else if (pick < 89) begin
        send_rx(hf);
        send_rx(hs ^ 8'($urandom_range(1, 255)));
      end else if (pick < 95) begin
        // cut-off frame: the next bytes get absorbed into its body
        send_rx(hf);
        send_rx(hs);
        repeat ($urandom_range(0, 8)) send_rx(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 3)) send_rx(8'($urandom_range(0, 255)));
      end
      // hold the stream once mid-phase until every frame is out
      if (!paused && bytes_sent - start >= 60) begin
        settle();
        paused = 1'b1;
      end
    end
    settle();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // all-zero frame under the reset register values
    repeat (FRAME_BYTES) send_rx(8'h00);
    settle();

    // bad second header equal to the first header is not retried,
    // then a frame whose bytes after the two headers are all ones
    load_regs(8'hFF, 8'h00, 8'hFF, 8'hFF);
    send_rx(8'hFF);
    send_rx(8'hFF);
    send_rx(8'h00);
    send_rx(8'hFF);
    send_rx(8'h00);
    repeat (FRAME_BYTES - 2) send_rx(8'hFF);
    settle();

    run_phase(0, 0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    run_phase(78, 0, 8'h00, 8'h00, 8'h00, 8'h00);
    run_phase(0, 78, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    run_phase(15, 15, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));

    $display("sent %0d bytes under %0d register settings, with and without idle and stall",
             bytes_sent, settings_used);
    $display("compared %0d decoded frames field by field", frames_checked);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
